>>> hdl/lpbc_pkg.sv
package lpbc_pkg;

  localparam int NUM_BUFFERS = 16;
  localparam int SLOT_W      = $clog2(NUM_BUFFERS);
  localparam int TAG_W       = 32;
  localparam int PIN_W       = 3;
  localparam int OP_W        = 2;
  localparam int STATUS_W    = 2;
  localparam int PORT_SLOT_W = 4;

  localparam logic [PIN_W-1:0] PIN_MAX = PIN_W'(7);

  localparam logic [OP_W-1:0] OP_ACQUIRE    = 2'd0;
  localparam logic [OP_W-1:0] OP_RELEASE    = 2'd1;
  localparam logic [OP_W-1:0] OP_MARK_DIRTY = 2'd2;
  localparam logic [OP_W-1:0] OP_INVALIDATE = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ALL_PIN  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_UNPINNED = 2'd2;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [TAG_W-1:0]  tag;
    logic              valid;
    logic              dirty;
    logic [PIN_W-1:0]  pin;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic                   cmp_en;
    logic                   upd_en;
    logic                   acq_ok;
    logic [OP_W-1:0]        op;
    logic [TAG_W-1:0]       page;
    logic [PORT_SLOT_W-1:0] slot;
  } cell_cmd_t;

  typedef struct packed {
    logic hit;
    logic free;
    logic sel;
  } cell_flags_t;

  function automatic logic [NUM_BUFFERS-1:0] reverse_bits(input logic [NUM_BUFFERS-1:0] v);
    logic [NUM_BUFFERS-1:0] r;
    for (int i = 0; i < NUM_BUFFERS; i++) begin
      r[i] = v[NUM_BUFFERS-1-i];
    end
    return r;
  endfunction

  function automatic logic [NUM_BUFFERS-1:0] lowest_set(input logic [NUM_BUFFERS-1:0] v);
    return v & (~v + NUM_BUFFERS'(1));
  endfunction

endpackage

>>> hdl/lru_page_buffer_cache.sv
// page buffer cache with most-recent-first ordering and pin counts
// input channel: in_valid_i / in_stall_o with opcode_i, page_index_i and
//   buffer_slot_i; opcodes acquire, release, mark dirty, invalidate all
// output channel: out_valid_o / out_stall_i with status_o, granted_slot_o,
//   hit_o, writeback_o and writeback_page_o; one result per input transfer
// each position of the recency list is a cell; a move to front shifts the
//   cells ahead of the chosen position down by one, all in the update step
// result path: compare in the cells, priority select, then update of the
//   row, which loads the result into the output register
// one item at a time: the input stalls through the compare, select and
//   update steps over the cell row; the next item is taken while a result
//   still waits in the output register
// receiver stall: the update step holds until the output register is free,
//   so the input stays stalled and no state changes
// reset: list holds slots in ascending order, all tags, marks and pin
//   counts cleared, no result pending
module lru_page_buffer_cache (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [lpbc_pkg::OP_W-1:0]        opcode_i,
  input  logic [lpbc_pkg::TAG_W-1:0]       page_index_i,
  input  logic [lpbc_pkg::PORT_SLOT_W-1:0] buffer_slot_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [lpbc_pkg::STATUS_W-1:0]    status_o,
  output logic [lpbc_pkg::PORT_SLOT_W-1:0] granted_slot_o,
  output logic                             hit_o,
  output logic                             writeback_o,
  output logic [lpbc_pkg::TAG_W-1:0]       writeback_page_o
);

  localparam int N = lpbc_pkg::NUM_BUFFERS;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CMP  = 2'd1;
  localparam logic [1:0] S_SEL  = 2'd2;
  localparam logic [1:0] S_UPD  = 2'd3;

  logic [1:0] state_q, state_d;

  logic [lpbc_pkg::OP_W-1:0]        op_q;
  logic [lpbc_pkg::TAG_W-1:0]       pg_q;
  logic [lpbc_pkg::PORT_SLOT_W-1:0] slot_q;

  lpbc_pkg::entry_t      chain [N+1];
  lpbc_pkg::cell_flags_t flags [N];
  lpbc_pkg::cell_cmd_t   cmd;

  logic [N-1:0] hit_v, free_v, sel_v;
  logic [N-1:0] hit_oh, free_oh, pos_oh;
  logic [N-1:0] pos_oh_q, shift_mask;
  lpbc_pkg::entry_t chosen, front_d, front_q;
  logic acq_ok_d, acq_ok_q;

  logic [lpbc_pkg::STATUS_W-1:0]    res_status_d, res_status_q;
  logic [lpbc_pkg::PORT_SLOT_W-1:0] res_granted_d, res_granted_q;
  logic                             res_hit_d, res_hit_q;
  logic                             res_wb_d, res_wb_q;
  logic [lpbc_pkg::TAG_W-1:0]       res_wbpage_d, res_wbpage_q;
  logic [lpbc_pkg::SLOT_W+lpbc_pkg::PORT_SLOT_W-1:0] chosen_ext;

  logic out_valid_q;
  logic out_free;
  logic in_xfer;
  logic upd_go;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign upd_go     = (state_q == S_UPD) && out_free;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_xfer) state_d = S_CMP;
      S_CMP:   state_d = S_SEL;
      S_SEL:   state_d = S_UPD;
      S_UPD:   if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  assign shift_mask = pos_oh_q | (pos_oh_q - N'(1));

  always_comb begin
    cmd.cmp_en = (state_q == S_CMP);
    cmd.upd_en = upd_go;
    cmd.acq_ok = acq_ok_q;
    cmd.op     = op_q;
    cmd.page   = pg_q;
    cmd.slot   = slot_q;
  end

  assign chain[0] = front_q;

  for (genvar i = 0; i < N; i++) begin : g_cell
    lpbc_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .reset_slot_i (lpbc_pkg::SLOT_W'(i)),
      .cmd_i        (cmd),
      .shift_i      (shift_mask[i]),
      .prev_i       (chain[i]),
      .entry_o      (chain[i+1]),
      .flags_o      (flags[i])
    );
    assign hit_v[i]  = flags[i].hit;
    assign free_v[i] = flags[i].free;
    assign sel_v[i]  = flags[i].sel;
  end

  assign hit_oh  = lpbc_pkg::lowest_set(hit_v);
  assign free_oh = lpbc_pkg::reverse_bits(lpbc_pkg::lowest_set(lpbc_pkg::reverse_bits(free_v)));
  assign pos_oh  = (|hit_v) ? hit_oh : free_oh;

  always_comb begin
    chosen = '0;
    for (int i = 0; i < N; i++) begin
      chosen = lpbc_pkg::entry_t'(chosen | (chain[i+1] & {lpbc_pkg::ENTRY_W{pos_oh[i]}}));
    end
  end

  assign chosen_ext = {{lpbc_pkg::PORT_SLOT_W{1'b0}}, chosen.slot};

  always_comb begin
    front_d       = chosen;
    acq_ok_d      = 1'b0;
    res_status_d  = lpbc_pkg::ST_OK;
    res_granted_d = '0;
    res_hit_d     = 1'b0;
    res_wb_d      = 1'b0;
    res_wbpage_d  = '0;
    unique case (op_q)
      lpbc_pkg::OP_ACQUIRE: begin
        if (|hit_v) begin
          acq_ok_d      = 1'b1;
          res_hit_d     = 1'b1;
          res_granted_d = chosen_ext[lpbc_pkg::PORT_SLOT_W-1:0];
          if (chosen.pin != lpbc_pkg::PIN_MAX) begin
            front_d.pin = chosen.pin + lpbc_pkg::PIN_W'(1);
          end
        end else if (|free_v) begin
          acq_ok_d      = 1'b1;
          res_granted_d = chosen_ext[lpbc_pkg::PORT_SLOT_W-1:0];
          res_wb_d      = chosen.dirty;
          res_wbpage_d  = chosen.dirty ? chosen.tag : '0;
          front_d.tag   = pg_q;
          front_d.valid = 1'b1;
          front_d.dirty = 1'b0;
          front_d.pin   = lpbc_pkg::PIN_W'(1);
        end else begin
          res_status_d = lpbc_pkg::ST_ALL_PIN;
        end
      end
      lpbc_pkg::OP_RELEASE: begin
        if (|(sel_v & free_v)) begin
          res_status_d = lpbc_pkg::ST_UNPINNED;
        end
      end
      default: begin
        res_status_d = lpbc_pkg::ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      acq_ok_q    <= 1'b0;
      pos_oh_q    <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == S_SEL) begin
        acq_ok_q <= acq_ok_d;
        pos_oh_q <= acq_ok_d ? pos_oh : '0;
      end
      if (upd_go) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      op_q   <= opcode_i;
      pg_q   <= page_index_i;
      slot_q <= buffer_slot_i;
    end
    if (state_q == S_SEL) begin
      front_q       <= front_d;
      res_status_q  <= res_status_d;
      res_granted_q <= res_granted_d;
      res_hit_q     <= res_hit_d;
      res_wb_q      <= res_wb_d;
      res_wbpage_q  <= res_wbpage_d;
    end
    if (upd_go) begin
      status_o         <= res_status_q;
      granted_slot_o   <= res_granted_q;
      hit_o            <= res_hit_q;
      writeback_o      <= res_wb_q;
      writeback_page_o <= res_wbpage_q;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  a_cmp_to_sel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CMP |=> state_q == S_SEL)
    else $error("compare step not followed by select");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> state_q == S_CMP)
    else $error("input transfer did not start a compare");

  a_pos_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(pos_oh_q))
    else $error("more than one list position chosen");

  a_slot_unique: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SEL |-> $onehot0(sel_v))
    else $error("buffer slot held by more than one cell");

  a_full_no_grant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == lpbc_pkg::ST_ALL_PIN |-> granted_slot_o == '0 && !hit_o)
    else $error("failed acquire reports a grant");
`endif

endmodule

>>> hdl/lpbc_cell.sv
module lpbc_cell (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [lpbc_pkg::SLOT_W-1:0] reset_slot_i,
  input  lpbc_pkg::cell_cmd_t  cmd_i,
  input  logic                 shift_i,
  input  lpbc_pkg::entry_t     prev_i,
  output lpbc_pkg::entry_t     entry_o,
  output lpbc_pkg::cell_flags_t flags_o
);

  lpbc_pkg::entry_t      ent_q, ent_d;
  lpbc_pkg::cell_flags_t flags_q, flags_d;
  logic [lpbc_pkg::SLOT_W+lpbc_pkg::PORT_SLOT_W-1:0] own_ext, req_ext;

  assign own_ext = {{lpbc_pkg::PORT_SLOT_W{1'b0}}, ent_q.slot};
  assign req_ext = {{lpbc_pkg::SLOT_W{1'b0}}, cmd_i.slot};

  always_comb begin
    flags_d = flags_q;
    if (cmd_i.cmp_en) begin
      flags_d.hit  = ent_q.valid && (ent_q.tag == cmd_i.page);
      flags_d.free = (ent_q.pin == '0);
      flags_d.sel  = (own_ext == req_ext);
    end
  end

  always_comb begin
    ent_d = ent_q;
    if (cmd_i.upd_en) begin
      unique case (cmd_i.op)
        lpbc_pkg::OP_ACQUIRE: begin
          if (cmd_i.acq_ok && shift_i) begin
            ent_d = prev_i;
          end
        end
        lpbc_pkg::OP_RELEASE: begin
          if (flags_q.sel && !flags_q.free) begin
            ent_d.pin = ent_q.pin - lpbc_pkg::PIN_W'(1);
          end
        end
        lpbc_pkg::OP_MARK_DIRTY: begin
          if (flags_q.sel) begin
            ent_d.dirty = 1'b1;
          end
        end
        lpbc_pkg::OP_INVALIDATE: begin
          ent_d.valid = 1'b0;
        end
        default: begin
          ent_d = ent_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_q.slot  <= reset_slot_i;
      ent_q.tag   <= '0;
      ent_q.valid <= 1'b0;
      ent_q.dirty <= 1'b0;
      ent_q.pin   <= '0;
      flags_q     <= '0;
    end else begin
      ent_q   <= ent_d;
      flags_q <= flags_d;
    end
  end

  assign entry_o = ent_q;
  assign flags_o = flags_q;

endmodule

>>> dv/tb_lru_page_buffer_cache.sv
`timescale 1ns / 100ps

module tb_lru_page_buffer_cache;

  typedef struct packed {
    logic [lpbc_pkg::OP_W-1:0]        op;
    logic [lpbc_pkg::TAG_W-1:0]       page;
    logic [lpbc_pkg::PORT_SLOT_W-1:0] slot;
  } cache_req_t;

  typedef struct packed {
    logic [lpbc_pkg::STATUS_W-1:0]    status;
    logic [lpbc_pkg::PORT_SLOT_W-1:0] slot;
    logic                             hit;
    logic                             wb;
    logic [lpbc_pkg::TAG_W-1:0]       wb_page;
  } cache_resp_t;

  localparam int POOL_SIZE = 24;
  localparam int RAND_PER_PHASE = 450;

  logic                             clk_i = 1'b0;
  logic                             rst_ni = 1'b0;
  logic                             in_valid_i = 1'b0;
  logic                             in_stall_o;
  logic [lpbc_pkg::OP_W-1:0]        opcode_i = lpbc_pkg::OP_ACQUIRE;
  logic [lpbc_pkg::TAG_W-1:0]       page_index_i = '0;
  logic [lpbc_pkg::PORT_SLOT_W-1:0] buffer_slot_i = '0;
  logic                             out_valid_o;
  logic                             out_stall_i = 1'b0;
  logic [lpbc_pkg::STATUS_W-1:0]    status_o;
  logic [lpbc_pkg::PORT_SLOT_W-1:0] granted_slot_o;
  logic                             hit_o;
  logic                             writeback_o;
  logic [lpbc_pkg::TAG_W-1:0]       writeback_page_o;

  // shadow copy of the cache state
  logic [lpbc_pkg::SLOT_W-1:0] lru_order [lpbc_pkg::NUM_BUFFERS];
  logic [lpbc_pkg::TAG_W-1:0]  buf_tag   [lpbc_pkg::NUM_BUFFERS];
  logic                        buf_valid [lpbc_pkg::NUM_BUFFERS];
  logic                        buf_dirty [lpbc_pkg::NUM_BUFFERS];
  logic [lpbc_pkg::PIN_W-1:0]  buf_pin   [lpbc_pkg::NUM_BUFFERS];

  logic [lpbc_pkg::TAG_W-1:0] page_pool [POOL_SIZE];

  logic [lpbc_pkg::TAG_W-1:0] dir_pages [lpbc_pkg::NUM_BUFFERS] = '{
    32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_0001,
    32'h5555_5555, 32'hAAAA_AAAA, 32'h7FFF_FFFF, 32'hFFFF_FFFE,
    32'h0000_FFFF, 32'hFFFF_0000, 32'h1234_5678, 32'h8765_4321,
    32'h0F0F_0F0F, 32'hF0F0_F0F0, 32'h0000_0002, 32'h3C3C_3C3C
  };

  cache_req_t  request_q [$];
  cache_resp_t response_q [$];

  int send_idle_pct = 0;
  int stall_pct = 0;
  int err_count = 0;
  bit hold_go = 1'b0;
  logic hold_off = 1'b0;

  lru_page_buffer_cache uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .opcode_i         (opcode_i),
    .page_index_i     (page_index_i),
    .buffer_slot_i    (buffer_slot_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_o         (status_o),
    .granted_slot_o   (granted_slot_o),
    .hit_o            (hit_o),
    .writeback_o      (writeback_o),
    .writeback_page_o (writeback_page_o)
  );

  always #2 clk_i = ~clk_i;

  function automatic cache_resp_t cache_access(cache_req_t req);
    cache_resp_t r;
    bit found;
    int pos;
    logic [lpbc_pkg::SLOT_W-1:0] s;
    r = '0;
    found = 1'b0;
    pos = 0;
    case (req.op)
      lpbc_pkg::OP_ACQUIRE: begin
        for (int i = 0; i < lpbc_pkg::NUM_BUFFERS; i++) begin
          if (!found && buf_valid[lru_order[i]] && buf_tag[lru_order[i]] == req.page) begin
            found = 1'b1;
            pos = i;
          end
        end
        if (found) begin
          s = lru_order[pos];
          if (buf_pin[s] != lpbc_pkg::PIN_MAX) begin
            buf_pin[s] = buf_pin[s] + lpbc_pkg::PIN_W'(1);
          end
          r.hit = 1'b1;
        end else begin
          // victim: least recent unpinned buffer, tail first
          for (int i = lpbc_pkg::NUM_BUFFERS - 1; i >= 0; i--) begin
            if (!found && buf_pin[lru_order[i]] == '0) begin
              found = 1'b1;
              pos = i;
            end
          end
          if (found) begin
            s = lru_order[pos];
            if (buf_dirty[s]) begin
              r.wb = 1'b1;
              r.wb_page = buf_tag[s];
              buf_dirty[s] = 1'b0;
            end
            buf_tag[s] = req.page;
            buf_valid[s] = 1'b1;
            buf_pin[s] = lpbc_pkg::PIN_W'(1);
          end else begin
            r.status = lpbc_pkg::ST_ALL_PIN;
          end
        end
        if (found) begin
          r.slot = lpbc_pkg::PORT_SLOT_W'(s);
          for (int i = pos; i > 0; i--) lru_order[i] = lru_order[i-1];
          lru_order[0] = s;
        end
      end
      lpbc_pkg::OP_RELEASE: begin
        if (req.slot < lpbc_pkg::NUM_BUFFERS) begin
          if (buf_pin[req.slot] == '0) r.status = lpbc_pkg::ST_UNPINNED;
          else buf_pin[req.slot] = buf_pin[req.slot] - lpbc_pkg::PIN_W'(1);
        end
      end
      lpbc_pkg::OP_MARK_DIRTY: begin
        if (req.slot < lpbc_pkg::NUM_BUFFERS) buf_dirty[req.slot] = 1'b1;
      end
      default: begin
        for (int i = 0; i < lpbc_pkg::NUM_BUFFERS; i++) buf_valid[i] = 1'b0;
      end
    endcase
    return r;
  endfunction

  function automatic cache_req_t random_req();
    cache_req_t req;
    int roll;
    int pick;
    req.page = $urandom;
    req.slot = lpbc_pkg::PORT_SLOT_W'($urandom_range(0, 2**lpbc_pkg::PORT_SLOT_W - 1));
    roll = $urandom_range(0, 99);
    if (roll < 40) req.op = lpbc_pkg::OP_ACQUIRE;
    else if (roll < 85) req.op = lpbc_pkg::OP_RELEASE;
    else if (roll < 97) req.op = lpbc_pkg::OP_MARK_DIRTY;
    else req.op = lpbc_pkg::OP_INVALIDATE;
    if (req.op == lpbc_pkg::OP_ACQUIRE) begin
      // mostly a small working set so that hits and pin build-up happen
      pick = $urandom_range(0, 9);
      if (pick < 7) req.page = page_pool[$urandom_range(0, POOL_SIZE - 1)];
      else if (pick == 9) req.page = $urandom_range(0, 1) ? '1 : '0;
    end
    return req;
  endfunction

  task automatic push_req(logic [lpbc_pkg::OP_W-1:0] op, logic [lpbc_pkg::TAG_W-1:0] page,
                          logic [lpbc_pkg::PORT_SLOT_W-1:0] slot);
    cache_req_t req;
    req.op = op;
    req.page = page;
    req.slot = slot;
    request_q.push_back(req);
  endtask

  task automatic check_field(string name, logic [lpbc_pkg::TAG_W-1:0] want,
                             logic [lpbc_pkg::TAG_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      err_count++;
    end
  endtask

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        response_q.push_back(cache_access({opcode_i, page_index_i, buffer_slot_i}));
      end
      if (!in_valid_i || !in_stall_o) begin
        if (request_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          cache_req_t nxt;
          nxt = request_q.pop_front();
          in_valid_i <= 1'b1;
          opcode_i <= nxt.op;
          page_index_i <= nxt.page;
          buffer_slot_i <= nxt.slot;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (response_q.size() == 0) begin
          $error("result transfer with nothing expected");
          err_count++;
        end else begin
          cache_resp_t want;
          want = response_q.pop_front();
          check_field("status", lpbc_pkg::TAG_W'(want.status), lpbc_pkg::TAG_W'(status_o));
          check_field("granted_slot", lpbc_pkg::TAG_W'(want.slot),
                      lpbc_pkg::TAG_W'(granted_slot_o));
          check_field("hit", lpbc_pkg::TAG_W'(want.hit), lpbc_pkg::TAG_W'(hit_o));
          check_field("writeback", lpbc_pkg::TAG_W'(want.wb), lpbc_pkg::TAG_W'(writeback_o));
          check_field("writeback_page", want.wb_page, writeback_page_o);
        end
      end
      out_stall_i <= hold_off || ($urandom_range(0, 99) < stall_pct);
    end
  end

  // long receiver hold-off so the block backs up and stalls its input
  initial begin
    wait (hold_go);
    @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (300) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  initial begin
    for (int i = 0; i < lpbc_pkg::NUM_BUFFERS; i++) begin
      lru_order[i] = lpbc_pkg::SLOT_W'(i);
      buf_tag[i] = '0;
      buf_valid[i] = 1'b0;
      buf_dirty[i] = 1'b0;
      buf_pin[i] = '0;
    end
    for (int i = 0; i < POOL_SIZE; i++) page_pool[i] = $urandom;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // release of an unpinned buffer, dirty tail evicted by the first miss
    push_req(lpbc_pkg::OP_RELEASE, '0, 4'd0);
    push_req(lpbc_pkg::OP_MARK_DIRTY, '0, 4'd15);
    for (int i = 0; i < lpbc_pkg::NUM_BUFFERS; i++) begin
      push_req(lpbc_pkg::OP_ACQUIRE, dir_pages[i], 4'd15);
    end
    // every buffer pinned
    push_req(lpbc_pkg::OP_ACQUIRE, 32'h1357_2468, 4'd0);
    // hits drive one pin count to its ceiling and past it
    for (int i = 0; i < 7; i++) push_req(lpbc_pkg::OP_ACQUIRE, 32'hFFFF_FFFF, 4'd0);
    // invalidate keeps pins, so a former hit now misses and finds no victim
    push_req(lpbc_pkg::OP_INVALIDATE, '1, 4'd15);
    push_req(lpbc_pkg::OP_ACQUIRE, 32'h0000_0000, 4'd0);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 86; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 86; end
        default: begin send_idle_pct = 10; stall_pct = 10; end
      endcase
      for (int n = 0; n < RAND_PER_PHASE; n++) request_q.push_back(random_req());
      if (ph == 0) hold_go = 1'b1;
      while (request_q.size() != 0 || in_valid_i) @(negedge clk_i);
    end

    while (response_q.size() != 0) @(negedge clk_i);
    repeat (8) @(posedge clk_i);
    if (err_count == 0) $display("tb_lru_page_buffer_cache: done, clean");
    else $display("tb_lru_page_buffer_cache: done, errors");
    $finish;
  end

  initial begin
    #4000000;
    $display("tb_lru_page_buffer_cache: done, errors");
    $finish;
  end

endmodule
